[rtl/mpr_pkg.sv]
// Shared types and constants for the magnitude/phase recombiner.
// Holds the CORDIC arctangent table, gain constant and control codes.
// No dependencies.
`default_nettype none

package mpr_pkg;

  localparam int GUARD_BITS = 4;
  localparam int INVK_FRAC  = 20;
  localparam logic signed [20:0] INVK_Q = 21'sd636751;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // register indexes
  localparam logic [1:0] REG_AMP_CPLX = 2'd0;
  localparam logic [1:0] REG_PH_SRC   = 2'd1;

  // phase source codes
  localparam logic [1:0] PH_NONE     = 2'd0;
  localparam logic [1:0] PH_REAL     = 2'd1;
  localparam logic [1:0] PH_CPLX     = 2'd2;
  localparam logic [1:0] PH_CPLX_ALT = 2'd3;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_MOD  = 2'd1,
    MODE_ROT  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  amp_cplx;
    logic  ph_real;
    logic  ph_zero;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/mpr_cordic_cell.sv]
// One CORDIC micro-rotation cell, vectoring or rotating, registered output.
// Depends on mpr_pkg for the arctangent table.
`default_nettype none

module mpr_cordic_cell
  import mpr_pkg::*;
#(
  parameter int W    = 23,
  parameter int ZW   = 32,
  parameter int IDX  = 0,
  parameter bit VECT = 1'b1
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic        [ZW-1:0] z_in,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic        [ZW-1:0]      z_out
);

  localparam logic [ZW-1:0] ATAN = ZW'(ATAN_TAB[IDX]);

  logic signed [W-1:0] dx, dy;
  logic                up;

  assign dx = x_in >>> IDX;
  assign dy = y_in >>> IDX;
  // up: x += y>>i, y -= x>>i, angle += atan
  assign up = VECT ? !y_in[W-1] : z_in[ZW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (up) begin
        x_out <= x_in + (y_in >>> IDX);
        y_out <= y_in - dx;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - (y_in >>> IDX);
        y_out <= y_in + dx;
        z_out <= z_in - ATAN;
      end
    end
  end

  logic unused_dy;
  assign unused_dy = ^dy;

endmodule

`default_nettype wire

[rtl/magnitude_phase_recombiner.sv]
// Top level: polar to rectangular recombination, amp * e^(i*phase).
// Depends on mpr_pkg and mpr_cordic_cell.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: amp_re, amp_im, ph_re, ph_im
//  m_      | out | m_tvalid/m_tready | m_tdata: out_re, out_im
//  cfg_    | in  | cfg_we            | cfg_addr, cfg_data
//
// One request per cycle while the output is not stalled. Stages in order: entry stage,
// vectoring cells, gain multiply, rounding/quadrant stage, rotating cells,
// output multiply, output register. The whole row of cells advances
// whenever the output register is empty or being taken; otherwise it holds.
// rst clears the valid bits and both config registers.
`default_nettype none

module magnitude_phase_recombiner
  import mpr_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // amp_re, amp_im, ph_re, ph_im from bit 0 up, zero padded
  input  wire logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // out_re, out_im from bit 0 up, zero padded
  output logic [((2*SAMPLE_WIDTH+2+7)/8)*8-1:0] m_tdata,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [1:0] cfg_data
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int N   = CORDIC_STAGES;
  localparam int W   = SW + 7;
  localparam int OW  = SW + 1;
  localparam int PW  = W + 21;
  localparam int RZW = 34;
  localparam int DWO = ((2*SAMPLE_WIDTH+2+7)/8)*8;
  localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (OW-1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(64'sd1 <<< (OW-1));

  function automatic logic signed [OW-1:0] rnd_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + (PW'(1) <<< (INVK_FRAC + GUARD_BITS - 1))) >>> (INVK_FRAC + GUARD_BITS);
    if (t > SAT_HI) return SAT_HI[OW-1:0];
    if (t < SAT_LO) return SAT_LO[OW-1:0];
    return t[OW-1:0];
  endfunction

  // config
  logic       amp_cplx;
  logic [1:0] ph_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_cplx <= 1'b0;
      ph_src   <= PH_NONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AMP_CPLX: amp_cplx <= cfg_data[0];
        REG_PH_SRC:   ph_src   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid;
  assign en = !out_valid || m_tready;
  assign s_tready = en;

  // entry decode
  logic signed [SW-1:0] a_re, a_im, p_re, p_im;
  logic signed [W-1:0]  ax, ay, px, py;
  ctl_t ctl_in;

  assign a_re = s_tdata[SW-1:0];
  assign a_im = s_tdata[2*SW-1:SW];
  assign p_re = s_tdata[3*SW-1:2*SW];
  assign p_im = s_tdata[4*SW-1:3*SW];
  assign ax = {{3{a_re[SW-1]}}, a_re, 4'b0};
  assign ay = {{3{a_im[SW-1]}}, a_im, 4'b0};
  assign px = {{7{p_re[SW-1]}}, p_re};
  assign py = {{7{p_im[SW-1]}}, p_im};

  always_comb begin
    ctl_in.amp_cplx = amp_cplx;
    ctl_in.ph_real  = (ph_src == PH_REAL);
    ctl_in.ph_zero  = (p_re == '0) && (p_im == '0);
    case (ph_src)
      PH_NONE: ctl_in.mode = amp_cplx ? MODE_MOD : MODE_PASS;
      default: ctl_in.mode = MODE_ROT;
    endcase
  end

  // vectoring row: amplitude and phase chains side by side
  logic signed [W-1:0] vax [N+1];
  logic signed [W-1:0] vay [N+1];
  logic [31:0]         vaz [N+1];
  logic signed [W-1:0] vpx [N+1];
  logic signed [W-1:0] vpy [N+1];
  logic [31:0]         vpz [N+1];
  logic                vv  [N+1];
  ctl_t                vctl [N+1];
  logic [SW-1:0]       va_re [N+1];
  logic [SW-1:0]       vp_re [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ax < 0) begin
        vax[0] <= -ax;
        vay[0] <= -ay;
        vaz[0] <= HALF_TURN;
      end else begin
        vax[0] <= ax;
        vay[0] <= ay;
        vaz[0] <= '0;
      end
      if (px < 0) begin
        vpx[0] <= -px;
        vpy[0] <= -py;
        vpz[0] <= HALF_TURN;
      end else begin
        vpx[0] <= px;
        vpy[0] <= py;
        vpz[0] <= '0;
      end
      vctl[0]  <= ctl_in;
      va_re[0] <= a_re;
      vp_re[0] <= p_re;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_vect
    mpr_cordic_cell #(.W(W), .ZW(32), .IDX(k), .VECT(1'b1)) u_amp (
      .clk, .en,
      .x_in(vax[k]), .y_in(vay[k]), .z_in(vaz[k]),
      .x_out(vax[k+1]), .y_out(vay[k+1]), .z_out(vaz[k+1])
    );
    mpr_cordic_cell #(.W(W), .ZW(32), .IDX(k), .VECT(1'b1)) u_ph (
      .clk, .en,
      .x_in(vpx[k]), .y_in(vpy[k]), .z_in(vpz[k]),
      .x_out(vpx[k+1]), .y_out(vpy[k+1]), .z_out(vpz[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        vctl[k+1]  <= vctl[k];
        va_re[k+1] <= va_re[k];
        vp_re[k+1] <= vp_re[k];
      end
    end
  end

  // gain multiply stage
  logic signed [PW-1:0] g_prod;
  logic [31:0]          g_ang;
  ctl_t                 g_ctl;
  logic [SW-1:0]        g_a_re;
  logic                 g_v;

  always_ff @(posedge clk) begin
    if (en) begin
      g_prod <= PW'(vax[N]) * PW'(INVK_Q);
      if (vctl[N].ph_real)
        g_ang <= 32'(vp_re[N]) << (32 - SW);
      else if (vctl[N].ph_zero)
        g_ang <= '0;
      else
        g_ang <= vpz[N];
      g_ctl  <= vctl[N];
      g_a_re <= va_re[N];
    end
  end

  // rounding and quadrant fold, feeding the rotating row
  logic signed [W-1:0]  rx [N+1];
  logic signed [W-1:0]  ry [N+1];
  logic [RZW-1:0]       rz [N+1];
  logic                 rv [N+1];
  mode_t                rmode [N+1];
  logic signed [OW-1:0] rpass [N+1];

  logic signed [PW-1:0] g_rnd;
  logic signed [W-1:0]  g_amp;
  logic [31:0]          g_ang_f;
  logic                 g_flip;

  always_comb begin
    g_rnd   = (g_prod + (PW'(1) <<< (INVK_FRAC - 1))) >>> INVK_FRAC;
    g_amp   = g_ctl.amp_cplx ? g_rnd[W-1:0]
                             : {{3{g_a_re[SW-1]}}, g_a_re, 4'b0};
    g_flip  = (g_ang[31:30] == 2'b01) || (g_ang[31:30] == 2'b10);
    g_ang_f = g_flip ? g_ang + HALF_TURN : g_ang;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0]    <= g_flip ? -g_amp : g_amp;
      ry[0]    <= '0;
      rz[0]    <= {{(RZW-32){g_ang_f[31]}}, g_ang_f};
      rmode[0] <= g_ctl.mode;
      rpass[0] <= (g_ctl.mode == MODE_MOD) ? rnd_sat(g_prod)
                                           : {g_a_re[SW-1], g_a_re};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    mpr_cordic_cell #(.W(W), .ZW(RZW), .IDX(k), .VECT(1'b0)) u_rot (
      .clk, .en,
      .x_in(rx[k]), .y_in(ry[k]), .z_in(rz[k]),
      .x_out(rx[k+1]), .y_out(ry[k+1]), .z_out(rz[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        rmode[k+1] <= rmode[k];
        rpass[k+1] <= rpass[k];
      end
    end
  end

  // output gain multiply
  logic signed [PW-1:0] f_px, f_py;
  mode_t                f_mode;
  logic signed [OW-1:0] f_pass;
  logic                 f_v;

  always_ff @(posedge clk) begin
    if (en) begin
      f_px   <= PW'(rx[N]) * PW'(INVK_Q);
      f_py   <= PW'(ry[N]) * PW'(INVK_Q);
      f_mode <= rmode[N];
      f_pass <= rpass[N];
    end
  end

  // output register
  logic signed [OW-1:0] out_re, out_im;

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_mode == MODE_ROT) begin
        out_re <= rnd_sat(f_px);
        out_im <= rnd_sat(f_py);
      end else begin
        out_re <= f_pass;
        out_im <= '0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) begin
        vv[i] <= 1'b0;
        rv[i] <= 1'b0;
      end
      g_v       <= 1'b0;
      f_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vv[0] <= s_tvalid;
      for (int i = 0; i < N; i++) begin
        vv[i+1] <= vv[i];
        rv[i+1] <= rv[i];
      end
      g_v       <= vv[N];
      rv[0]     <= g_v;
      f_v       <= rv[N];
      out_valid <= f_v;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = DWO'({out_im, out_re});

  logic unused;
  assign unused = ^{vay[N], vpx[N], vpy[N], vaz[N], ry[0], rz[N], ry[N] ^ ry[N],
                    g_rnd[PW-1:W], s_tdata};

endmodule

`default_nettype wire
